// File: hdl/life_grid_generation_top_macros.svh
// Assertion macros used by the life grid top level.
// Each macro expands to one labelled concurrent assertion clocked on clk, disabled in rst.
`ifndef LIFE_GRID_GENERATION_TOP_MACROS_SVH
`define LIFE_GRID_GENERATION_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define LGG_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("life grid check failed");

// When pre holds, post holds at the following clock edge.
`define LGG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("life grid check failed");

// When pre holds, post holds at the same clock edge.
`define LGG_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("life grid check failed");

`endif

// File: hdl/lgg_pkg.sv
// Shared types and constants for the life grid block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lgg_pkg;

  // Grid geometry.
  localparam int unsigned GRID_SIZE = 32;
  localparam int unsigned IDX_W     = $clog2(GRID_SIZE);

  // Field widths of the streams.
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned S_DATA_W  = 16;
  localparam int unsigned M_DATA_W  = 8;

  // Life rule constants.
  localparam int unsigned BIRTH_COUNT = 3;
  localparam int unsigned DEATH_COUNT = 4;
  localparam int unsigned SURVIVE_MIN = 2;

  typedef logic [GRID_SIZE-1:0] row_t;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_t;

  // Control bundle that the top level broadcasts to every row cell.
  typedef struct packed {
    logic             shift;
    logic             write;
    logic [IDX_W-1:0] wr_col;
    logic             wr_bit;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/lgg_next_row.sv
// Life rule for one row: next row from the rows above, here and below.
// Depends on lgg_pkg for the grid size and rule constants.
`default_nettype none

module lgg_next_row
  import lgg_pkg::*;
(
  input  row_t above,
  input  row_t here,
  input  row_t below,
  output row_t next
);

  // Rows padded with a dead cell on either side, so the edges see no wrap.
  logic [GRID_SIZE+1:0] above_pad;
  logic [GRID_SIZE+1:0] here_pad;
  logic [GRID_SIZE+1:0] below_pad;

  assign above_pad = {1'b0, above, 1'b0};
  assign here_pad  = {1'b0, here,  1'b0};
  assign below_pad = {1'b0, below, 1'b0};

  // Each column counts its eight neighbours independently.
  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < GRID_SIZE; c++) begin
      n = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
        + 4'(here_pad[c])                        + 4'(here_pad[c+2])
        + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
      if (here[c]) begin
        next[c] = (n >= 4'(SURVIVE_MIN)) && (n < 4'(DEATH_COUNT));
      end else begin
        next[c] = (n == 4'(BIRTH_COUNT));
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/lgg_row_cell.sv
// One row cell of the grid chain: holds a row, takes a single-cell write,
// and during a sweep takes the row of its neighbour. Depends on lgg_pkg.
`default_nettype none

module lgg_row_cell
  import lgg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       hit,
  input  row_t       shift_in,
  output row_t       data
);

  row_t data_next;

  // A sweep shift has the grid to itself; otherwise a write may touch one bit.
  always_comb begin
    data_next = data;
    if (ctrl.shift) begin
      data_next = shift_in;
    end else if (ctrl.write && hit) begin
      data_next[ctrl.wr_col] = ctrl.wr_bit;
    end
  end

  // The grid starts all dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/life_grid_generation_top.sv
// Top level of the life grid block: stream ports, controller, row chain and rule unit.
// Depends on lgg_pkg, lgg_row_cell, lgg_next_row and the assertion macro header.
`default_nettype none

// Conway's Life on a 32 x 32 grid with dead cells beyond the edge, all dead after
// reset. Each request on the slave stream writes a cell, reads a cell or advances
// one generation, and gives exactly one result on the master stream (op_done is 0
// for an unknown request). For writes, reads and unknown requests the result
// appears in the output register on the next cycle, so with a ready sink one
// such request is taken every cycle. An advance shifts the rows through a chain
// of row cells past a single rule unit, one row per cycle, until all GRID_SIZE
// (32) rows have passed. The result is loaded with the last shift, and the next
// request can be taken once the controller is back in idle. A new request is
// taken while the controller is idle and the output register is empty or being
// emptied.

`include "life_grid_generation_top_macros.svh"

module life_grid_generation_top
  import lgg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata: req_type [1:0], row [6:2], col [11:7], cell_in [12], zero [15:13]
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata: cell_out [0], op_done [1], zero [7:2]
  output logic [M_DATA_W-1:0] m_tdata
);

  // Request fields.
  logic [REQ_W-1:0] req_type;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic             cell_in;
  logic             s_unused;

  assign req_type = s_tdata[1:0];
  assign row      = s_tdata[6:2];
  assign col      = s_tdata[11:7];
  assign cell_in  = s_tdata[12];
  assign s_unused = ^s_tdata[S_DATA_W-1:13];

  // Column index at the width of the grid.
  logic [IDX_W+POS_W-1:0] col_ext;
  logic [IDX_W-1:0]       col_idx;
  logic                   on_grid;

  assign col_ext = {{IDX_W{1'b0}}, col};
  assign col_idx = col_ext[IDX_W-1:0];
  assign on_grid = (32'(row) < GRID_SIZE) && (32'(col) < GRID_SIZE);

  // Controller and result registers.
  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] sweep_cnt;
  logic [IDX_W-1:0] sweep_cnt_next;
  row_t             above;
  row_t             above_next;
  logic             out_valid;
  logic             out_valid_next;
  logic             out_cell;
  logic             out_cell_next;
  logic             out_done;
  logic             out_done_next;

  logic       accept;
  logic       sweep_last;
  cell_ctrl_t ctrl;

  row_t             row_data [GRID_SIZE];
  logic [GRID_SIZE-1:0] hit;
  row_t             rd_row;
  row_t             below;
  row_t             new_row;

  assign accept     = s_tvalid && s_tready;
  assign sweep_last = (sweep_cnt == IDX_W'(GRID_SIZE - 1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req_t'(req_type) == REQ_ADVANCE)) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs: handshake, cell control and sweep bookkeeping.
  always_comb begin
    s_tready       = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.write     = 1'b0;
    ctrl.wr_col    = col_idx;
    ctrl.wr_bit    = cell_in;
    sweep_cnt_next = sweep_cnt;
    above_next     = above;
    unique case (state)
      ST_IDLE: begin
        s_tready       = !out_valid || m_tready;
        ctrl.write     = accept && (req_t'(req_type) == REQ_WRITE) && on_grid;
        sweep_cnt_next = '0;
        above_next     = '0;
      end
      ST_SWEEP: begin
        ctrl.shift     = 1'b1;
        sweep_cnt_next = sweep_cnt + IDX_W'(1);
        above_next     = row_data[0];
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Result register: loaded on a finished request, cleared when taken.
  always_comb begin
    out_valid_next = out_valid;
    out_cell_next  = out_cell;
    out_done_next  = out_done;
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
    if (accept && (req_t'(req_type) != REQ_ADVANCE)) begin
      out_valid_next = 1'b1;
      out_cell_next  = (req_t'(req_type) == REQ_READ) && on_grid && rd_row[col_idx];
      out_done_next  = (req_t'(req_type) != REQ_NONE);
    end else if ((state == ST_SWEEP) && sweep_last) begin
      out_valid_next = 1'b1;
      out_cell_next  = 1'b0;
      out_done_next  = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers; the row above starts dead at every sweep.
  always_ff @(posedge clk) begin
    sweep_cnt <= sweep_cnt_next;
    above     <= above_next;
    out_cell  <= out_cell_next;
    out_done  <= out_done_next;
  end

  // Row selection for writes and reads.
  always_comb begin
    rd_row = '0;
    for (int i = 0; i < GRID_SIZE; i++) begin
      hit[i] = (32'(row) == 32'(i));
      if (hit[i]) begin
        rd_row = rd_row | row_data[i];
      end
    end
  end

  // Rule unit at the head of the chain; the last row sees a dead row below.
  assign below = sweep_last ? '0 : row_data[1];

  lgg_next_row u_next_row (
    .above (above),
    .here  (row_data[0]),
    .below (below),
    .next  (new_row)
  );

  // Chain of row cells: each takes its neighbour's row, the tail takes the new row.
  for (genvar g = 0; g < GRID_SIZE; g++) begin : g_cell
    row_t shift_in;
    if (g == GRID_SIZE - 1) begin : g_tail
      assign shift_in = new_row;
    end else begin : g_body
      assign shift_in = row_data[g+1];
    end

    lgg_row_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .hit      (hit[g]),
      .shift_in (shift_in),
      .data     (row_data[g])
    );
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - 2){s_unused & 1'b0}}, out_done, out_cell};

  // Shorthands for the checks below.
  logic take_advance;
  logic sweep_first;
  logic sweep_end;
  logic reply_done_only;

  assign take_advance    = accept && (req_t'(req_type) == REQ_ADVANCE);
  assign sweep_first     = (state == ST_SWEEP) && (sweep_cnt == '0);
  assign sweep_end       = (state == ST_SWEEP) && sweep_last;
  assign reply_done_only = m_tvalid && m_tdata[1] && !m_tdata[0];

  // Checks on the controller and result logic.
  `LGG_ASSERT_SAME(a_no_accept_in_sweep, state == ST_SWEEP, !s_tready)
  `LGG_ASSERT_SAME(a_read_implies_done, m_tvalid && m_tdata[0], m_tdata[1])
  `LGG_ASSERT_NEXT(a_advance_starts_sweep, take_advance, sweep_first && !m_tvalid)
  `LGG_ASSERT_NEXT(a_sweep_gives_result, sweep_end, reply_done_only && (state == ST_IDLE))

endmodule

`default_nettype wire
